[sv/rsv_pkg.sv]
// ----------------------------------------------------------------------------
// rsv_pkg: shared types and constants
// Command codes, register indexes, fixed field widths, sequencer states and
// the control word that travels with each beat through the MAC pipeline.
// ----------------------------------------------------------------------------
package rsv_pkg;

    localparam int VAL_W  = 18;   // load value, kernel weight, compatibility
    localparam int PROB_W = 16;   // stored probability, 0..32768
    localparam int PROD_W = 35;   // weight times probability
    localparam int KERN_W = 3;    // kernel extent, half width, tap counter
    localparam int POS_W  = 5;
    localparam int DIMR_W = 6;    // volume size registers
    localparam int DIM_W  = 7;    // limited volume size
    localparam int CLS_W  = 4;    // class count register
    localparam int SUP_W  = 48;

    typedef enum logic [1:0] {
        CMD_LOAD_PROB   = 2'd0,
        CMD_LOAD_WEIGHT = 2'd1,
        CMD_LOAD_COMPAT = 2'd2,
        CMD_COMPUTE     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_VOLUME_X    = 3'd0,
        CFG_VOLUME_Y    = 3'd1,
        CFG_VOLUME_Z    = 3'd2,
        CFG_CLASS_COUNT = 3'd3,
        CFG_KERNEL_X    = 3'd4,
        CFG_KERNEL_Y    = 3'd5,
        CFG_KERNEL_Z    = 3'd6,
        CFG_EDGE_MODE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_MIX,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic valid;
        logic mix;
        logic zero;
        logic last;
        logic out_last;
    } t_ctl;

    function automatic int f_aw(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

[sv/rsv_store.sv]
// ----------------------------------------------------------------------------
// rsv_store: probability, kernel weight and compatibility memories
// One write port and one registered read port per memory.
// ----------------------------------------------------------------------------
module rsv_store #(
    parameter int MAX_DIM     = 32,
    parameter int MAX_KERNEL  = 5,
    parameter int MAX_CLASSES = 8
) (
    input  logic i_clk,
    input  logic i_p_we,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES*MAX_DIM*MAX_DIM*MAX_DIM)-1:0] i_p_waddr,
    input  logic [rsv_pkg::PROB_W-1:0] i_p_wdata,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES*MAX_DIM*MAX_DIM*MAX_DIM)-1:0] i_p_raddr,
    output logic [rsv_pkg::PROB_W-1:0] o_p_rdata,
    input  logic i_w_we,
    input  logic [rsv_pkg::f_aw(MAX_KERNEL*MAX_KERNEL*MAX_KERNEL)-1:0] i_w_waddr,
    input  logic signed [rsv_pkg::VAL_W-1:0] i_w_wdata,
    input  logic [rsv_pkg::f_aw(MAX_KERNEL*MAX_KERNEL*MAX_KERNEL)-1:0] i_w_raddr,
    output logic signed [rsv_pkg::VAL_W-1:0] o_w_rdata,
    input  logic i_c_we,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES*MAX_CLASSES)-1:0] i_c_waddr,
    input  logic signed [rsv_pkg::VAL_W-1:0] i_c_wdata,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES*MAX_CLASSES)-1:0] i_c_raddr,
    output logic signed [rsv_pkg::VAL_W-1:0] o_c_rdata
);
    import rsv_pkg::*;

    localparam int PDEPTH = MAX_CLASSES * MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int WDEPTH = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
    localparam int CDEPTH = MAX_CLASSES * MAX_CLASSES;

    logic [PROB_W-1:0]        r_pmem [PDEPTH];
    logic signed [VAL_W-1:0]  r_wmem [WDEPTH];
    logic signed [VAL_W-1:0]  r_cmem [CDEPTH];

    always_ff @(posedge i_clk) begin
        if (i_p_we) begin
            r_pmem[i_p_waddr] <= i_p_wdata;
        end
        o_p_rdata <= r_pmem[i_p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_wmem[i_w_waddr] <= i_w_wdata;
        end
        o_w_rdata <= r_wmem[i_w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_c_we) begin
            r_cmem[i_c_waddr] <= i_c_wdata;
        end
        o_c_rdata <= r_cmem[i_c_raddr];
    end

endmodule

[sv/rsv_mac.sv]
// ----------------------------------------------------------------------------
// rsv_mac: shared multiply-accumulate pipeline
// One multiplier serves both the neighborhood taps and the class mixing.
// Holds the per-class neighborhood sums, rounds and saturates the support.
// ----------------------------------------------------------------------------
module rsv_mac #(
    parameter int MAX_KERNEL  = 5,
    parameter int MAX_CLASSES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  rsv_pkg::t_ctl i_ctl,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES)-1:0] i_m,
    input  logic [rsv_pkg::f_aw(MAX_CLASSES)-1:0] i_l,
    input  logic [rsv_pkg::PROB_W-1:0] i_pdata,
    input  logic signed [rsv_pkg::VAL_W-1:0] i_wdata,
    input  logic signed [rsv_pkg::VAL_W-1:0] i_cdata,
    output logic o_pipe_busy,
    output logic o_strobe,
    output logic [2:0] o_class_index,
    output logic signed [rsv_pkg::SUP_W-1:0] o_support_value,
    output logic o_last
);
    import rsv_pkg::*;

    localparam int CLW = f_aw(MAX_CLASSES);
    localparam int AW  = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL * MAX_KERNEL + 1);
    localparam int MW  = AW + VAL_W;
    localparam int SW  = MW + $clog2(MAX_CLASSES + 1);
    localparam int EW  = (SW > 64) ? SW : 64;

    logic signed [AW-1:0] r_nei [MAX_CLASSES];
    t_ctl                 r1_ctl, r2_ctl;
    logic [CLW-1:0]       r1_m, r1_l, r2_m, r2_l, r_fin_l;
    logic signed [AW-1:0] r1_nei;
    logic signed [MW-1:0] r2_prod;
    logic signed [SW-1:0] r_acc, r_fin;
    logic                 r_fin_v, r_fin_last;

    logic signed [AW-1:0] w_a;
    logic signed [VAL_W-1:0] w_b;
    logic signed [SW-1:0] w_sum;
    logic signed [EW-1:0] w_rnd, w_q;
    logic                 w_fits;
    logic signed [SUP_W-1:0] w_sat;

    always_comb begin
        if (r1_ctl.mix) begin
            w_a = r1_nei;
            w_b = i_cdata;
        end else begin
            w_a = r1_ctl.zero ? '0 : AW'($signed({1'b0, i_pdata}));
            w_b = i_wdata;
        end
    end

    assign w_sum  = r_acc + SW'(r2_prod);
    assign w_rnd  = EW'(r_fin) + (EW'(1) << 14);
    assign w_q    = w_rnd >>> 15;
    assign w_fits = (&w_q[EW-1:SUP_W-1]) | ~(|w_q[EW-1:SUP_W-1]);
    assign w_sat  = w_fits ? w_q[SUP_W-1:0] :
                    (w_q[EW-1] ? {1'b1, {(SUP_W-1){1'b0}}} : {1'b0, {(SUP_W-1){1'b1}}});

    assign o_pipe_busy = r1_ctl.valid | r2_ctl.valid | r_fin_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl   <= '0;
            r2_ctl   <= '0;
            r_acc    <= '0;
            r_fin_v  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r1_ctl   <= i_ctl;
            r2_ctl   <= r1_ctl;
            r_fin_v  <= r2_ctl.valid & r2_ctl.last & r2_ctl.mix;
            o_strobe <= r_fin_v;
            if (r2_ctl.valid) begin
                r_acc <= r2_ctl.last ? '0 : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m    <= i_m;
        r1_l    <= i_l;
        r1_nei  <= r_nei[i_m];
        r2_m    <= r1_m;
        r2_l    <= r1_l;
        r2_prod <= w_a * w_b;
        if (r2_ctl.valid && r2_ctl.last) begin
            if (r2_ctl.mix) begin
                r_fin      <= w_sum;
                r_fin_l    <= r2_l;
                r_fin_last <= r2_ctl.out_last;
            end else begin
                r_nei[r2_m] <= w_sum[AW-1:0];
            end
        end
        o_class_index   <= 3'(r_fin_l);
        o_support_value <= w_sat;
        o_last          <= r_fin_last;
    end

`ifndef SYNTH
    a_fin_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_v |-> $past(r2_ctl.valid && r2_ctl.mix && r2_ctl.last))
        else $error("support beat without closing mix beat");
    a_strobe_follows_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_v |=> o_strobe)
        else $error("finished support not presented");
    a_no_mixed_phases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_ctl.valid && r2_ctl.valid) |-> (r1_ctl.mix == r2_ctl.mix || r2_ctl.last))
        else $error("tap and mix beats interleaved");
`endif

endmodule

[sv/relaxation_support_voxel_3d.sv]
// ----------------------------------------------------------------------------
// relaxation_support_voxel_3d: relaxation-labeling support for one voxel
// Load commands return no beat and leave busy low. A compute command holds
// busy high while the single shared multiplier, doing one product per cycle
// in the tap and mix phases, works through nc*T weight-probability products,
// with nc the classes in use and T the kernel taps; then the pipeline drains,
// the nc*nc compatibility products follow, and the pipeline is flushed. The
// next command is taken as soon as busy is low. Support beats come in class
// order, each marked by a one-cycle strobe; the last leaves in the final busy
// cycle. The receiver cannot hold beats off.
// ----------------------------------------------------------------------------
module relaxation_support_voxel_3d #(
    parameter int MAX_DIM     = 32,
    parameter int MAX_KERNEL  = 5,
    parameter int MAX_CLASSES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] i_cmd,
    input  logic [2:0] i_class_a,
    input  logic [2:0] i_class_b,
    input  logic [4:0] i_pos_x,
    input  logic [4:0] i_pos_y,
    input  logic [4:0] i_pos_z,
    input  logic signed [17:0] i_load_value,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    output logic o_strobe,
    output logic [2:0] o_class_index,
    output logic signed [47:0] o_support_value,
    output logic o_last
);
    import rsv_pkg::*;

    localparam int PAW  = f_aw(MAX_CLASSES * MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int WAW  = f_aw(MAX_KERNEL * MAX_KERNEL * MAX_KERNEL);
    localparam int CAW  = f_aw(MAX_CLASSES * MAX_CLASSES);
    localparam int CLW  = f_aw(MAX_CLASSES);
    localparam int CNW  = $clog2(MAX_CLASSES + 1);
    localparam int DW   = f_aw(MAX_DIM);
    localparam int HMAX = (MAX_KERNEL - 1) / 2;

    typedef struct packed {
        logic       zero;
        logic [7:0] c;
    } t_coord;

    function automatic t_coord f_coord(input logic [POS_W-1:0] p, input logic [KERN_W-1:0] t,
                                       input logic [KERN_W-1:0] h, input logic [DIM_W-1:0] n,
                                       input logic em);
        logic signed [8:0] c;
        t_coord r;
        c = $signed({4'b0, p}) + $signed({6'b0, t}) - $signed({6'b0, h});
        r.zero = 1'b0;
        r.c    = c[7:0];
        if (c < 0) begin
            r.zero = !em;
            r.c    = '0;
        end else if (c >= $signed({2'b0, n})) begin
            r.zero = !em;
            r.c    = {1'b0, n} - 8'd1;
        end
        return r;
    endfunction

    function automatic logic [KERN_W-1:0] f_half(input logic [KERN_W-1:0] e);
        logic [KERN_W-1:0] h;
        h = (e == '0) ? '0 : (e - 1'b1) >> 1;
        if (int'(h) > HMAX) h = KERN_W'(HMAX);
        return h;
    endfunction

    function automatic logic [DIM_W-1:0] f_dim(input logic [DIMR_W-1:0] v);
        logic [DIM_W-1:0] n;
        n = {1'b0, v};
        if (v == '0) n = DIM_W'(1);
        else if (int'(v) > MAX_DIM) n = DIM_W'(MAX_DIM);
        return n;
    endfunction

    logic [DIMR_W-1:0] r_vol_x, r_vol_y, r_vol_z;
    logic [CLS_W-1:0]  r_cls;
    logic [KERN_W-1:0] r_kx, r_ky, r_kz;
    logic              r_edge;

    t_state            r_state, n_state;
    logic [CLW-1:0]    r_m, n_m, r_l, n_l;
    logic [KERN_W-1:0] r_ti, n_ti, r_tj, n_tj, r_tk, n_tk;
    logic [POS_W-1:0]  r_px, r_py, r_pz;

    logic              w_accept, w_pipe_busy;
    t_ctl              w_ctl;
    logic [KERN_W-1:0] w_hx, w_hy, w_hz;
    logic [DIM_W-1:0]  w_nx, w_ny, w_nz;
    logic [CNW-1:0]    w_nc;
    logic [CLW-1:0]    w_ncm1;
    t_coord            w_cx, w_cy, w_cz;
    logic              w_tlast;

    logic              w_p_we, w_w_we, w_c_we;
    logic [PAW-1:0]    w_p_waddr, w_p_raddr;
    logic [WAW-1:0]    w_w_waddr, w_w_raddr;
    logic [CAW-1:0]    w_c_waddr, w_c_raddr;
    logic [PROB_W-1:0] w_p_wdata, w_p_rdata;
    logic signed [VAL_W-1:0] w_w_rdata, w_c_rdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_x <= DIMR_W'(32);
            r_vol_y <= DIMR_W'(32);
            r_vol_z <= DIMR_W'(32);
            r_cls   <= CLS_W'(2);
            r_kx    <= KERN_W'(3);
            r_ky    <= KERN_W'(3);
            r_kz    <= KERN_W'(3);
            r_edge  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOLUME_X:    r_vol_x <= i_cfg_data;
                CFG_VOLUME_Y:    r_vol_y <= i_cfg_data;
                CFG_VOLUME_Z:    r_vol_z <= i_cfg_data;
                CFG_CLASS_COUNT: r_cls   <= i_cfg_data[CLS_W-1:0];
                CFG_KERNEL_X:    r_kx    <= i_cfg_data[KERN_W-1:0];
                CFG_KERNEL_Y:    r_ky    <= i_cfg_data[KERN_W-1:0];
                CFG_KERNEL_Z:    r_kz    <= i_cfg_data[KERN_W-1:0];
                CFG_EDGE_MODE:   r_edge  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // load side
    always_comb begin
        w_p_we = w_accept && (i_cmd == CMD_LOAD_PROB) && (int'(i_class_a) < MAX_CLASSES) &&
                 (int'(i_pos_x) < MAX_DIM) && (int'(i_pos_y) < MAX_DIM) &&
                 (int'(i_pos_z) < MAX_DIM);
        w_w_we = w_accept && (i_cmd == CMD_LOAD_WEIGHT) && (int'(i_pos_x) < MAX_KERNEL) &&
                 (int'(i_pos_y) < MAX_KERNEL) && (int'(i_pos_z) < MAX_KERNEL);
        w_c_we = w_accept && (i_cmd == CMD_LOAD_COMPAT) &&
                 (int'(i_class_a) < MAX_CLASSES) && (int'(i_class_b) < MAX_CLASSES);
        w_p_waddr = PAW'(((int'(i_class_a) * MAX_DIM + int'(i_pos_z)) * MAX_DIM
                          + int'(i_pos_y)) * MAX_DIM + int'(i_pos_x));
        w_w_waddr = WAW'((int'(i_pos_z) * MAX_KERNEL + int'(i_pos_y)) * MAX_KERNEL
                         + int'(i_pos_x));
        w_c_waddr = CAW'(int'(i_class_a) * MAX_CLASSES + int'(i_class_b));
        if (i_load_value < 0) w_p_wdata = '0;
        else if (i_load_value > 18'sd32768) w_p_wdata = 16'h8000;
        else w_p_wdata = i_load_value[PROB_W-1:0];
    end

    // compute side
    always_comb begin
        w_hx = f_half(r_kx);
        w_hy = f_half(r_ky);
        w_hz = f_half(r_kz);
        w_nx = f_dim(r_vol_x);
        w_ny = f_dim(r_vol_y);
        w_nz = f_dim(r_vol_z);
        if (r_cls == '0) w_nc = CNW'(1);
        else if (int'(r_cls) > MAX_CLASSES) w_nc = CNW'(MAX_CLASSES);
        else w_nc = CNW'(r_cls);
        w_ncm1 = CLW'(w_nc - 1'b1);
        w_cx = f_coord(r_px, r_ti, w_hx, w_nx, r_edge);
        w_cy = f_coord(r_py, r_tj, w_hy, w_ny, r_edge);
        w_cz = f_coord(r_pz, r_tk, w_hz, w_nz, r_edge);
        w_tlast = (r_ti == (w_hx << 1)) && (r_tj == (w_hy << 1)) && (r_tk == (w_hz << 1));
        w_p_raddr = PAW'(((int'(r_m) * MAX_DIM + int'(DW'(w_cz.c))) * MAX_DIM
                          + int'(DW'(w_cy.c))) * MAX_DIM + int'(DW'(w_cx.c)));
        w_w_raddr = WAW'((int'(r_tk) * MAX_KERNEL + int'(r_tj)) * MAX_KERNEL + int'(r_ti));
        w_c_raddr = CAW'(int'(r_m) * MAX_CLASSES + int'(r_l));
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_l     = r_l;
        n_ti    = r_ti;
        n_tj    = r_tj;
        n_tk    = r_tk;
        w_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                n_m  = '0;
                n_l  = '0;
                n_ti = '0;
                n_tj = '0;
                n_tk = '0;
                if (w_accept && i_cmd == CMD_COMPUTE) n_state = S_TAP;
            end
            S_TAP: begin
                w_ctl.valid = 1'b1;
                w_ctl.zero  = w_cx.zero | w_cy.zero | w_cz.zero;
                w_ctl.last  = w_tlast;
                if (r_tk != (w_hz << 1)) begin
                    n_tk = r_tk + 1'b1;
                end else begin
                    n_tk = '0;
                    if (r_tj != (w_hy << 1)) begin
                        n_tj = r_tj + 1'b1;
                    end else begin
                        n_tj = '0;
                        if (r_ti != (w_hx << 1)) begin
                            n_ti = r_ti + 1'b1;
                        end else begin
                            n_ti = '0;
                            if (r_m == w_ncm1) begin
                                n_m     = '0;
                                n_state = S_DRAIN;
                            end else begin
                                n_m = r_m + 1'b1;
                            end
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (!w_pipe_busy) n_state = S_MIX;
            end
            S_MIX: begin
                w_ctl.valid    = 1'b1;
                w_ctl.mix      = 1'b1;
                w_ctl.last     = (r_m == w_ncm1);
                w_ctl.out_last = (r_l == w_ncm1);
                if (r_m != w_ncm1) begin
                    n_m = r_m + 1'b1;
                end else begin
                    n_m = '0;
                    if (r_l == w_ncm1) n_state = S_FLUSH;
                    else n_l = r_l + 1'b1;
                end
            end
            S_FLUSH: begin
                if (!w_pipe_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_l  <= n_l;
        r_ti <= n_ti;
        r_tj <= n_tj;
        r_tk <= n_tk;
        if (w_accept) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
    end

    rsv_store #(
        .MAX_DIM     (MAX_DIM),
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_store (
        .i_clk     (i_clk),
        .i_p_we    (w_p_we),
        .i_p_waddr (w_p_waddr),
        .i_p_wdata (w_p_wdata),
        .i_p_raddr (w_p_raddr),
        .o_p_rdata (w_p_rdata),
        .i_w_we    (w_w_we),
        .i_w_waddr (w_w_waddr),
        .i_w_wdata (i_load_value),
        .i_w_raddr (w_w_raddr),
        .o_w_rdata (w_w_rdata),
        .i_c_we    (w_c_we),
        .i_c_waddr (w_c_waddr),
        .i_c_wdata (i_load_value),
        .i_c_raddr (w_c_raddr),
        .o_c_rdata (w_c_rdata)
    );

    rsv_mac #(
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_m             (r_m),
        .i_l             (r_l),
        .i_pdata         (w_p_rdata),
        .i_wdata         (w_w_rdata),
        .i_cdata         (w_c_rdata),
        .o_pipe_busy     (w_pipe_busy),
        .o_strobe        (o_strobe),
        .o_class_index   (o_class_index),
        .o_support_value (o_support_value),
        .o_last          (o_last)
    );

`ifndef SYNTH
    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("support beat outside a compute command");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("beat after last class");
    a_no_beat_in_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> !o_strobe)
        else $error("support beat during tap phase");
`endif

endmodule
